// ===== hw/rtl/pum_pkg.sv =====
package pum_pkg;

   localparam int SINE_INDEX_BITS_DEFAULT = 10;
   localparam int MAX_IMAGE_DIM_DEFAULT   = 4096;

   // field and datapath widths
   localparam int CENTER_W = 12;
   localparam int RADIUS_W = 20;
   localparam int STEP_W   = 16;
   localparam int ANGLE_W  = 32;
   localparam int ROW_W    = 12;
   localparam int COL_W    = 14;
   localparam int SRC_W    = 23;
   localparam int R12_W    = 29;
   localparam int MAG_W    = 15;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_RADIUS = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIAL_STEP  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP   = 8'd4;

   localparam logic [STEP_W-1:0] RADIAL_STEP_RESET = 16'd4096;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // word handed from the angle/radius front end to the sine lookup
   typedef struct packed {
      logic             valid;
      logic             sin_neg;
      logic             cos_neg;
      logic [R12_W-1:0] r12;
   } pum_tag_type;

   // first quadrant sine in q15 magnitude, f is the quadrant phase in q30 of a
   // quarter turn; only evaluated on constants to build the table
   function automatic logic [MAG_W-1:0] quarter_sine_q15(input logic [63:0] f);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] s;
      x    = (f * PI_Q30) >> 31;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd342; sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd420; sum = sum + signed'(term);
      if (sum < 0) begin
         sum = 0;
      end
      s = (sum + 64'sd16384) >>> 15;
      if (s > 64'sd32767) begin
         s = 64'sd32767;
      end
      return MAG_W'(s);
   endfunction

endpackage

// ===== hw/rtl/pum_polar_front.sv =====
module pum_polar_front
   import pum_pkg::*;
#(
   parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [ROW_W-1:0]           row,
   input  logic [COL_W-1:0]           col,
   input  logic [RADIUS_W-1:0]        inner_radius,
   input  logic [STEP_W-1:0]          radial_step,
   input  logic [ANGLE_W-1:0]         angle_step,
   output pum_tag_type                tag,
   output logic [SINE_INDEX_BITS-2:0] sin_addr,
   output logic [SINE_INDEX_BITS-2:0] cos_addr
);

   localparam int AW      = SINE_INDEX_BITS - 1;
   localparam int QUARTER = 1 << (SINE_INDEX_BITS - 2);
   localparam logic [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1) << (31 - SINE_INDEX_BITS);

   logic                       v1_ff;
   logic [R12_W-1:0]           r12_ff;
   logic [R12_W-1:0]           r12_in;
   logic [ANGLE_W-1:0]         angle_ff;
   logic [ANGLE_W-1:0]         angle_in;
   logic [27:0]                row_prod;
   logic [ANGLE_W-1:0]         idx_sum;
   logic [SINE_INDEX_BITS-1:0] sin_idx;
   logic [SINE_INDEX_BITS-1:0] cos_idx;
   pum_tag_type                tag_ff;
   pum_tag_type                tag_in;
   logic [AW-1:0]              sin_addr_ff;
   logic [AW-1:0]              sin_addr_in;
   logic [AW-1:0]              cos_addr_ff;
   logic [AW-1:0]              cos_addr_in;

   // stage 1: radius and angle products
   assign row_prod = 28'(row) * 28'(radial_step);
   assign r12_in   = R12_W'({inner_radius, 4'b0000}) + R12_W'(row_prod);
   assign angle_in = ANGLE_W'(col) * angle_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r12_ff   <= r12_in;
         angle_ff <= angle_in;
      end
   end

   // stage 2: round angle to table index, fold into first quadrant
   assign idx_sum = angle_ff + ROUND_HALF;
   assign sin_idx = idx_sum[ANGLE_W-1 -: SINE_INDEX_BITS];
   assign cos_idx = sin_idx + SINE_INDEX_BITS'(QUARTER);

   always_comb begin
      if (sin_idx[SINE_INDEX_BITS-2]) begin
         sin_addr_in = AW'(QUARTER) - AW'(sin_idx[SINE_INDEX_BITS-3:0]);
      end else begin
         sin_addr_in = AW'(sin_idx[SINE_INDEX_BITS-3:0]);
      end
      if (cos_idx[SINE_INDEX_BITS-2]) begin
         cos_addr_in = AW'(QUARTER) - AW'(cos_idx[SINE_INDEX_BITS-3:0]);
      end else begin
         cos_addr_in = AW'(cos_idx[SINE_INDEX_BITS-3:0]);
      end
      tag_in.valid   = v1_ff;
      tag_in.sin_neg = sin_idx[SINE_INDEX_BITS-1];
      tag_in.cos_neg = cos_idx[SINE_INDEX_BITS-1];
      tag_in.r12     = r12_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_addr_ff <= sin_addr_in;
         cos_addr_ff <= cos_addr_in;
      end
   end

   assign tag      = tag_ff;
   assign sin_addr = sin_addr_ff;
   assign cos_addr = cos_addr_ff;

endmodule

// ===== hw/rtl/pum_sine_rom.sv =====
module pum_sine_rom
   import pum_pkg::*;
#(
   parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  pum_tag_type                tag_in,
   input  logic [SINE_INDEX_BITS-2:0] sin_addr,
   input  logic [SINE_INDEX_BITS-2:0] cos_addr,
   output pum_tag_type                tag_out,
   output logic [MAG_W-1:0]           sin_mag,
   output logic [MAG_W-1:0]           cos_mag
);

   localparam int QUARTER = 1 << (SINE_INDEX_BITS - 2);

   // quarter wave table, entry k is the magnitude at k/(4*QUARTER) turn
   logic [MAG_W-1:0] rom_q [QUARTER+1];
   pum_tag_type      tag_ff;
   logic [MAG_W-1:0] sin_mag_ff;
   logic [MAG_W-1:0] cos_mag_ff;

   for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
      assign rom_q[k] = quarter_sine_q15(64'(k) << (32 - SINE_INDEX_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_mag_ff <= rom_q[sin_addr];
         cos_mag_ff <= rom_q[cos_addr];
      end
   end

   assign tag_out = tag_ff;
   assign sin_mag = sin_mag_ff;
   assign cos_mag = cos_mag_ff;

endmodule

// ===== hw/rtl/pum_place.sv =====
module pum_place
   import pum_pkg::*;
#(
   parameter int MAX_IMAGE_DIM = MAX_IMAGE_DIM_DEFAULT
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [R12_W-1:0]        r12,
   input  logic [MAG_W-1:0]        mag,
   input  logic                    neg,
   input  logic [CENTER_W-1:0]     center,
   output logic signed [SRC_W-1:0] src
);

   localparam int PROD_W = R12_W + MAG_W;
   localparam int OFF_W  = PROD_W - 19 + 1;
   localparam int SUM_W  = OFF_W + 2;
   localparam logic [CENTER_W:0] CENTER_MAX = (CENTER_W + 1)'(MAX_IMAGE_DIM - 1);
   localparam logic signed [SUM_W-1:0] OUT_LOW  = -(SUM_W'(2097152));
   localparam logic signed [SUM_W-1:0] OUT_HIGH = SUM_W'(4194303);

   logic [PROD_W-1:0]       prod_ff;
   logic                    neg_ff;
   logic [PROD_W:0]         rounded;
   logic [OFF_W-1:0]        off_mag;
   logic signed [SUM_W-1:0] off;
   logic [CENTER_W-1:0]     center_sat;
   logic signed [SUM_W-1:0] base;
   logic signed [SUM_W-1:0] total;
   logic signed [SRC_W-1:0] src_ff;
   logic signed [SRC_W-1:0] src_in;

   // stage 4: radius times trig magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_W'(r12) * PROD_W'(mag);
         neg_ff  <= neg;
      end
   end

   // stage 5: round half away from zero, add center, clamp
   assign rounded = (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(1 << 18);
   assign off_mag = OFF_W'(rounded >> 19);
   assign off     = neg_ff ? -signed'(SUM_W'(off_mag)) : signed'(SUM_W'(off_mag));

   always_comb begin
      if ({1'b0, center} > CENTER_MAX) begin
         center_sat = CENTER_W'(CENTER_MAX);
      end else begin
         center_sat = center;
      end
      base  = signed'(SUM_W'({center_sat, 8'h00}));
      total = base + off;
      if (total < OUT_LOW) begin
         src_in = SRC_W'(OUT_LOW);
      end else if (total > OUT_HIGH) begin
         src_in = SRC_W'(OUT_HIGH);
      end else begin
         src_in = SRC_W'(total);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         src_ff <= src_in;
      end
   end

   assign src = src_ff;

endmodule

// ===== hw/rtl/polar_unwarp_coordinate_map.sv =====
// polar to cartesian fisheye unwarp coordinate map: for each panorama pixel
// (row, column) the block returns the fisheye source point in 1/256 pixel,
// src = center*256 + radius*(sin, cos)(angle), with radius = inner_radius +
// row*radial_step and angle = column*angle_step as a 32-bit fraction of a
// turn. sine and cosine come from a quarter-wave q0.15 table with
// 2^SINE_INDEX_BITS points per turn, rounded to the nearest point. the
// pipeline is five register stages deep (radius/angle multiply, index round
// and quadrant fold, table read, radius*trig multiply, round/offset/clamp),
// so one word is taken every clock unless a result is held on the rsp side. a
// result held on the rsp side stalls the whole pipeline in place; nothing is
// dropped or repeated. configuration writes are accepted in any cycle but must
// only be issued while no word is in flight.
module polar_unwarp_coordinate_map
   import pum_pkg::*;
#(
   parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEFAULT,
   parameter int MAX_IMAGE_DIM   = MAX_IMAGE_DIM_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   // panorama pixel in
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ROW_W-1:0]        req_pano_row,
   input  logic [COL_W-1:0]        req_pano_col,
   // source coordinate out
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SRC_W-1:0] rsp_src_x,
   output logic signed [SRC_W-1:0] rsp_src_y
);

   localparam int AW = SINE_INDEX_BITS - 1;

   logic [CENTER_W-1:0] center_x_ff;
   logic [CENTER_W-1:0] center_y_ff;
   logic [RADIUS_W-1:0] inner_radius_ff;
   logic [STEP_W-1:0]   radial_step_ff;
   logic [ANGLE_W-1:0]  angle_step_ff;

   logic                en;
   pum_tag_type         front_tag;
   logic [AW-1:0]       sin_addr;
   logic [AW-1:0]       cos_addr;
   pum_tag_type         rom_tag;
   logic [MAG_W-1:0]    sin_mag;
   logic [MAG_W-1:0]    cos_mag;
   logic                v4_ff;
   logic                v5_ff;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         inner_radius_ff <= '0;
         radial_step_ff  <= RADIAL_STEP_RESET;
         angle_step_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_X:     center_x_ff     <= csr_wdata[CENTER_W-1:0];
            CSR_CENTER_Y:     center_y_ff     <= csr_wdata[CENTER_W-1:0];
            CSR_INNER_RADIUS: inner_radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_RADIAL_STEP:  radial_step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_ANGLE_STEP:   angle_step_ff   <= csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the output word is waiting
   assign en        = !v5_ff || rsp_ready;
   assign req_ready = en;

   // stages 1-2
   pum_polar_front #(
      .SINE_INDEX_BITS(SINE_INDEX_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .row          (req_pano_row),
      .col          (req_pano_col),
      .inner_radius (inner_radius_ff),
      .radial_step  (radial_step_ff),
      .angle_step   (angle_step_ff),
      .tag          (front_tag),
      .sin_addr     (sin_addr),
      .cos_addr     (cos_addr)
   );

   // stage 3
   pum_sine_rom #(
      .SINE_INDEX_BITS(SINE_INDEX_BITS)
   ) u_rom (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .tag_in   (front_tag),
      .sin_addr (sin_addr),
      .cos_addr (cos_addr),
      .tag_out  (rom_tag),
      .sin_mag  (sin_mag),
      .cos_mag  (cos_mag)
   );

   // valid for stages 4-5, the placement units carry only payload
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= rom_tag.valid;
         v5_ff <= v4_ff;
      end
   end

   // stages 4-5, x uses sine and y uses cosine
   pum_place #(
      .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
   ) u_place_x (
      .clock  (clock),
      .en     (en),
      .r12    (rom_tag.r12),
      .mag    (sin_mag),
      .neg    (rom_tag.sin_neg),
      .center (center_x_ff),
      .src    (rsp_src_x)
   );

   pum_place #(
      .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
   ) u_place_y (
      .clock  (clock),
      .en     (en),
      .r12    (rom_tag.r12),
      .mag    (cos_mag),
      .neg    (rom_tag.cos_neg),
      .center (center_y_ff),
      .src    (rsp_src_y)
   );

   assign rsp_valid = v5_ff;

endmodule
